>>> rtl/relative_strength_index_defines.svh
// Assertion macros shared by the relative strength index RTL.
`ifndef RELATIVE_STRENGTH_INDEX_DEFINES_SVH
`define RELATIVE_STRENGTH_INDEX_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define RSI_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("relative_strength_index: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled during reset.
`define RSI_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("relative_strength_index: next-cycle check failed");

`endif

>>> rtl/rsi_pkg.sv
// Package with the widths, constants and sequencer states of the RSI block.
`timescale 1ns / 1ps

package rsi_pkg;

	localparam int PRICE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Averages wrap modulo 2^64.
	localparam int AVG_W = 64;
	// Period register and warm-up counter width.
	localparam int CNT_W = 16;
	// Result width and fixed-point scale of the result.
	localparam int RSI_W     = 23;
	localparam int RSI_SHIFT = 16;

	localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(14);
	localparam logic [RSI_W-1:0] RSI_FULL     = RSI_W'(100 << RSI_SHIFT);

	// 100 * 2^16 = 25 * 2^18: the numerator is g*25 shifted left by SCALE_SH.
	localparam int SCALE_SH = RSI_SHIFT + 2;
	localparam int TOP_SH   = RSI_W - SCALE_SH;

	// Quotient bits retired per cycle by the division by the period.
	localparam int DIV_BPC    = 2;
	localparam int DIV_CYCLES = AVG_W / DIV_BPC;
	localparam int MUL_STEPS  = CNT_W;
	localparam int STEP_W     = $clog2(DIV_CYCLES);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PREP = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_DIV  = 9'b000001000,
		ST_SUM  = 9'b000010000,
		ST_SCL1 = 9'b000100000,
		ST_SCL2 = 9'b001000000,
		ST_RDIV = 9'b010000000,
		ST_OUT  = 9'b100000000
	} rsi_state_t;

endpackage

>>> rtl/relative_strength_index.sv
// After acceptance, a warm-up beat that completes no average goes from ST_PREP straight to ST_OUT.
// A smoothed beat runs 16 shift-add multiply steps, the two-bit-per-cycle division by the period,
// then a 23-step division for the ratio, which is skipped when the loss average is zero.
// One beat at a time; the next beat is taken once the result is in the output register.
// Reset (arst_n low, asynchronous): period 14, previous price, warm-up count and averages zero.
`timescale 1ns / 1ps
`include "relative_strength_index_defines.svh"

module relative_strength_index
	import rsi_pkg::*;
#(
	parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CNT_W-1:0]       averaging_period,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PRICE_WIDTH-1:0] close_price,
	input  logic                   series_start,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [RSI_W-1:0]       rsi_value,
	output logic                   rsi_valid
);

	rsi_state_t state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] period_q;
	logic [PRICE_WIDTH-1:0] prev_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AVG_W-1:0] avg_g_q, avg_l_q;
	logic out_valid_q;

	logic [PRICE_WIDTH-1:0] price_q;
	logic start_q;
	logic [CNT_W-1:0] per_q;
	logic [AVG_W-1:0] acc_g_q, acc_l_q;
	logic [CNT_W-1:0] mpl_q;
	logic [CNT_W-1:0] rem_g_q, rem_l_q;
	logic [AVG_W-1:0] dvs_q;
	logic [AVG_W+1:0] scl_q;
	logic [AVG_W-1:0] rem_q;
	logic [RSI_W-1:0] lo_q;
	logic [RSI_W-1:0] res_val_q;
	logic res_ok_q;
	logic [RSI_W-1:0] rsi_value_q;
	logic rsi_valid_q;

	logic in_acc, out_free, step_done;
	logic up;
	logic [PRICE_WIDTH-1:0] diff;
	logic [AVG_W-1:0] move, gain, loss, sum_g, sum_l;
	logic [CNT_W-1:0] cnt_inc;
	logic warm;
	logic [AVG_W-1:0] mul_g, mul_l;
	logic [AVG_W-1:0] dg, dl;
	logic [CNT_W-1:0] rg, rl;
	logic [AVG_W:0] s_full;
	logic [AVG_W+1:0] tri3;
	logic [AVG_W+4:0] g25;
	logic [AVG_W:0] rt, rt_sub;
	logic r_ge;
	logic [AVG_W-1:0] rem_n;
	logic [RSI_W-1:0] lo_n;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign step_done = (step_q == '0);

	assign out_valid = out_valid_q;
	assign rsi_value = rsi_value_q;
	assign rsi_valid = rsi_valid_q;

	// Price move split into a gain or a loss, in fixed point.
	assign up      = price_q > prev_q;
	assign diff    = up ? (price_q - prev_q) : (prev_q - price_q);
	assign move    = AVG_W'(diff) << FRAC_BITS;
	assign gain    = up ? move : '0;
	assign loss    = up ? '0 : move;
	assign sum_g   = avg_g_q + gain;
	assign sum_l   = avg_l_q + loss;
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign warm    = cnt_q < per_q;

	// Shift-add multiply by (period - 1); the averages serve as multiplicands.
	assign mul_g = acc_g_q + (mpl_q[0] ? avg_g_q : '0);
	assign mul_l = acc_l_q + (mpl_q[0] ? avg_l_q : '0);

	// Restoring division by the period, both lanes, DIV_BPC quotient bits per cycle.
	always_comb begin
		logic [CNT_W:0] tg, tl, sg, sl;
		logic geg, gel;
		dg = acc_g_q;
		dl = acc_l_q;
		rg = rem_g_q;
		rl = rem_l_q;
		for (int k = 0; k < DIV_BPC; k++) begin
			tg  = {rg, dg[AVG_W-1]};
			tl  = {rl, dl[AVG_W-1]};
			sg  = tg - {1'b0, per_q};
			sl  = tl - {1'b0, per_q};
			geg = tg >= {1'b0, per_q};
			gel = tl >= {1'b0, per_q};
			rg  = geg ? sg[CNT_W-1:0] : tg[CNT_W-1:0];
			rl  = gel ? sl[CNT_W-1:0] : tl[CNT_W-1:0];
			dg  = {dg[AVG_W-2:0], geg};
			dl  = {dl[AVG_W-2:0], gel};
		end
	end

	assign s_full = {1'b0, acc_g_q} + {1'b0, acc_l_q};
	assign tri3   = {2'b00, acc_g_q} + {1'b0, acc_g_q, 1'b0};
	assign g25    = {scl_q, 3'b000} + {5'b00000, acc_g_q};

	// Ratio division: the quotient never exceeds full scale, so RSI_W steps suffice.
	assign rt     = {rem_q, lo_q[RSI_W-1]};
	assign rt_sub = rt - {1'b0, dvs_q};
	assign r_ge   = rt >= {1'b0, dvs_q};
	assign rem_n  = r_ge ? rt_sub[AVG_W-1:0] : rt[AVG_W-1:0];
	assign lo_n   = {lo_q[RSI_W-2:0], r_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			period_q    <= PERIOD_RESET;
			prev_q      <= '0;
			cnt_q       <= '0;
			avg_g_q     <= '0;
			avg_l_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= averaging_period;
			end
			// In ST_OUT the output register is reloaded below instead.
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					prev_q <= price_q;
					if (start_q) begin
						cnt_q   <= '0;
						avg_g_q <= '0;
						avg_l_q <= '0;
						state_q <= ST_OUT;
					end else if (warm) begin
						avg_g_q <= sum_g;
						avg_l_q <= sum_l;
						cnt_q   <= cnt_inc;
						if (cnt_inc >= per_q) begin
							step_q  <= STEP_W'(DIV_CYCLES - 1);
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						step_q  <= STEP_W'(MUL_STEPS - 1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					avg_g_q <= avg_g_q << 1;
					avg_l_q <= avg_l_q << 1;
					if (step_done) begin
						step_q  <= STEP_W'(DIV_CYCLES - 1);
						state_q <= ST_DIV;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DIV: begin
					if (step_done) begin
						avg_g_q <= dg;
						avg_l_q <= dl;
						state_q <= ST_SUM;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_SUM: begin
					if (acc_l_q == '0) begin
						state_q <= ST_OUT;
					end else if (!s_full[AVG_W]) begin
						state_q <= ST_SCL1;
					end
				end
				ST_SCL1: begin
					state_q <= ST_SCL2;
				end
				ST_SCL2: begin
					step_q  <= STEP_W'(RSI_W - 1);
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (step_done) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					price_q <= close_price;
					start_q <= series_start;
					per_q   <= (period_q == '0) ? CNT_W'(1) : period_q;
				end
			end
			ST_PREP: begin
				acc_g_q   <= warm ? sum_g : gain;
				acc_l_q   <= warm ? sum_l : loss;
				rem_g_q   <= '0;
				rem_l_q   <= '0;
				mpl_q     <= per_q - CNT_W'(1);
				res_val_q <= '0;
				res_ok_q  <= 1'b0;
			end
			ST_MUL: begin
				acc_g_q <= mul_g;
				acc_l_q <= mul_l;
				mpl_q   <= mpl_q >> 1;
			end
			ST_DIV: begin
				acc_g_q <= dg;
				acc_l_q <= dl;
				rem_g_q <= rg;
				rem_l_q <= rl;
			end
			ST_SUM: begin
				if (acc_l_q == '0) begin
					res_val_q <= RSI_FULL;
					res_ok_q  <= 1'b1;
				end else if (s_full[AVG_W]) begin
					// The sum does not fit in 64 bits: halve both and try again.
					acc_g_q <= acc_g_q >> 1;
					acc_l_q <= acc_l_q >> 1;
				end else begin
					dvs_q <= s_full[AVG_W-1:0];
				end
			end
			ST_SCL1: begin
				scl_q <= tri3;
			end
			ST_SCL2: begin
				rem_q <= g25[AVG_W+4:TOP_SH];
				lo_q  <= {g25[TOP_SH-1:0], {SCALE_SH{1'b0}}};
			end
			ST_RDIV: begin
				rem_q <= rem_n;
				lo_q  <= lo_n;
				if (step_done) begin
					res_val_q <= lo_n;
					res_ok_q  <= 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					rsi_value_q <= res_val_q;
					rsi_valid_q <= res_ok_q;
				end
			end
			default: begin
			end
		endcase
	end

	`RSI_ASSERT_NXT(a_accept_starts_work, in_acc, state_q == ST_PREP)
	`RSI_ASSERT_IMP(a_invalid_is_zero, out_valid && !rsi_valid, rsi_value == '0)
	`RSI_ASSERT_IMP(a_value_in_range, out_valid, rsi_value <= RSI_FULL)
	`RSI_ASSERT_IMP(a_period_rem_bound, state_q == ST_DIV, (rem_g_q < per_q) && (rem_l_q < per_q))
	`RSI_ASSERT_IMP(a_ratio_rem_bound, state_q == ST_RDIV, rem_q < dvs_q)

endmodule
